FILE: src/orb_pkg.sv
// shared types, codes and defaults for the overwriting ring buffer
package orb_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int ENTRY_WIDTH_DEF = 64;
  localparam int FIELD_W         = 64;
  localparam int CAP_W           = 7;
  localparam int REQ_W           = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [FIELD_W-1:0] entry_value;
    logic [CAP_W-1:0]   drop_count;
  } req_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] list_value;
    logic               is_last;
  } rsp_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } orb_state_t;

endpackage

FILE: src/overwriting_ring_buffer.sv
// overwriting ring buffer: index control, list sequencer and output staging
// append and remove: a new request may follow every cycle
// list: request port busy until the last word's ram read issues, also under rsp_ready stalls
// list words pass read stage and output register, one per cycle while rsp_ready is high
// output and ram read stage form a two-deep skid, so stalls on rsp_ready lose nothing
// reset: indices and count cleared, capacity 64; the entry ram itself is not cleared
module overwriting_ring_buffer
  import orb_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_word_t        req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_word_t        rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CAP_W + 1;

  orb_state_t state, state_next;

  logic [CAP_W-1:0]       capacity;
  logic [IW-1:0]          oldest_index;
  logic [IW-1:0]          newest_index;
  logic [CW-1:0]          fill_count;
  logic [IW-1:0]          rd_ptr;
  logic [CW-1:0]          left;
  logic                   dv;
  logic                   dv_last;
  logic                   out_valid;
  rsp_word_t              out_word;

  logic [CW-1:0]          size;
  logic                   accept;
  logic                   issue;
  logic                   move;
  logic [IW-1:0]          newest_step;
  logic [IW-1:0]          oldest_step;
  logic [IW-1:0]          rd_step;
  logic [SW-1:0]          drop_sum;
  logic [IW-1:0]          oldest_drop;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  // ring size from capacity, clamped to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      size = CW'(1);
    end else if (capacity > CAP_W'(DEPTH)) begin
      size = CW'(DEPTH);
    end else begin
      size = CW'(capacity);
    end
  end

  // wrapped index steps, all indices stay below size
  assign newest_step = (CW'(newest_index) + CW'(1) == size) ? '0 : newest_index + IW'(1);
  assign oldest_step = (CW'(oldest_index) + CW'(1) == size) ? '0 : oldest_index + IW'(1);
  assign rd_step     = (CW'(rd_ptr) + CW'(1) == size) ? '0 : rd_ptr + IW'(1);

  // oldest + drop stays below twice size, one subtract wraps it
  assign drop_sum    = SW'(oldest_index) + SW'(req.drop_count);
  assign oldest_drop = (drop_sum >= SW'(size)) ? IW'(drop_sum - SW'(size)) : IW'(drop_sum);

  // skid between ram read stage and output register
  assign move = dv && (!out_valid || rsp_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req.req_type == REQ_LIST && fill_count != '0) begin
          state_next = ST_LIST;
        end
      end
      ST_LIST: begin
        if (issue && left == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_ready = 1'b0;
    issue     = 1'b0;
    unique case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_LIST: issue = (!dv || move);
      default: req_ready = 1'b0;
    endcase
  end

  assign accept = req_valid && req_ready;

  // append write address
  assign ram_we    = accept && req.req_type == REQ_APPEND;
  assign ram_waddr = (fill_count == '0) ? '0 : newest_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring indices, count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAP_RESET;
      oldest_index <= '0;
      newest_index <= '0;
      fill_count   <= '0;
    end else if (cfg_we) begin
      capacity     <= cfg_data;
      oldest_index <= '0;
      newest_index <= '0;
      fill_count   <= '0;
    end else if (accept) begin
      unique case (req.req_type)
        REQ_APPEND: begin
          if (fill_count == '0) begin
            oldest_index <= '0;
            newest_index <= '0;
            fill_count   <= CW'(1);
          end else begin
            newest_index <= newest_step;
            if (fill_count >= size) begin
              oldest_index <= oldest_step;
            end else begin
              fill_count <= fill_count + CW'(1);
            end
          end
        end
        REQ_REMOVE: begin
          if (req.drop_count != '0 && SW'(req.drop_count) <= SW'(size)) begin
            if (SW'(req.drop_count) >= SW'(fill_count)) begin
              oldest_index <= '0;
              newest_index <= '0;
              fill_count   <= '0;
            end else begin
              oldest_index <= oldest_drop;
              fill_count   <= fill_count - CW'(req.drop_count);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // list read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (accept && req.req_type == REQ_LIST) begin
      rd_ptr <= oldest_index;
      left   <= fill_count;
    end else if (issue) begin
      rd_ptr <= rd_step;
      left   <= left - CW'(1);
    end
  end

  // ram read stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else if (issue) begin
      dv      <= 1'b1;
      dv_last <= (left == CW'(1));
    end else if (move) begin
      dv <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid           <= 1'b1;
      out_word.list_value <= FIELD_W'(ram_rdata);
      out_word.is_last    <= dv_last;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_word;

  orb_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req.entry_value[ENTRY_WIDTH-1:0]),
    .re   (issue),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  // count and indices stay inside the ring
  a_fill_in_ring: assert property (@(posedge clk) disable iff (rst)
    fill_count <= size && CW'(oldest_index) < size && CW'(newest_index) < size)
    else $error("ring index or count beyond ring size");

  // a list never reads more words than are held
  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    left <= fill_count)
    else $error("list read count exceeds fill count");

  // a list of a nonempty buffer starts the read sequencer
  a_list_start: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == REQ_LIST && fill_count != '0 |=> state == ST_LIST)
    else $error("list request did not start reads");

  // a held read word keeps its last mark until it moves out
  a_dv_hold: assert property (@(posedge clk) disable iff (rst)
    dv && !move |=> dv && $stable(dv_last))
    else $error("read stage word lost under stall");

  // reads only issue while listing
  a_issue_state: assert property (@(posedge clk) disable iff (rst)
    issue |-> state == ST_LIST && left != '0)
    else $error("ram read issued outside a list");

endmodule

FILE: src/orb_ram.sv
// generic single-write, single-read ram with registered read data
module orb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
